[rtl/core/bsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper package
// Request kinds, register indexes and address constants of the mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

  typedef enum logic [2:0] {
    REQ_CPU_MAP   = 3'd0,
    REQ_REG_WRITE = 3'd1,
    REQ_VID_MAP   = 3'd2,
    REQ_RAM_READ  = 3'd3,
    REQ_RAM_WRITE = 3'd4,
    REQ_TICK      = 3'd5
  } req_type_t;

  localparam logic CFG_PRG_BANK_COUNT    = 1'b0;
  localparam logic CFG_INITIAL_MIRRORING = 1'b1;

  localparam int CFG_DATA_W   = 7;
  localparam int MAP_ADDR_W   = 19;

  localparam logic [6:0]  PRG_BANK_COUNT_RST = 7'd2;
  localparam logic [15:0] VID_LIMIT          = 16'h2000;

  // Program window regions, selected by address bits 14:13 above 0x8000.
  localparam logic [1:0] REG_BANK = 2'd0;
  localparam logic [1:0] REG_MIRR = 2'd1;
  localparam logic [1:0] REG_IRQL = 2'd2;
  localparam logic [1:0] REG_IRQE = 2'd3;

  localparam int PRG_SWAP_BIT  = 6;
  localparam int CHR_SWAP_BIT  = 7;
  localparam int RAM_EN_BIT    = 7;
  localparam int RAM_WP_BIT    = 6;

endpackage

[rtl/core/bank_switch_mapper_with_scanline_irq_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper with scanline IRQ
// Cartridge bank mapper: address translation, mapper registers, save RAM and
// a scanline interrupt counter behind one request stream.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the request kind, s_tdata
// the bus address and write byte. Each request yields one result on the m_
// channel: translated address, save RAM byte, IRQ level and mirroring mode.
// The result is registered and appears the cycle after a request is taken.
// While the receiver keeps up and no clear runs, one request is taken every
// cycle; the translation, register update and counter step are each a single
// shallow lookup, and the save RAM read uses its one registered read port in
// the same cycle as the request. When the receiver stalls, the result stays
// in the output register and s_tready drops until it is taken.
// After reset the save RAM is cleared one byte per cycle; s_tready stays
// low during that pass. The configuration port may be written at any time,
// including the pass, but is only meant to change while no request is in
// flight.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq_top
  import bsm_pkg::*;
#(
  parameter int SAVE_RAM_DEPTH = 8192
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // address[15:0], write_data[23:16]
  input  logic [2:0]            s_tuser,   // req_type[2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // mapped_address[18:0], read_data[26:19], irq_pending[27], mirroring[28]
  output logic [31:0]           m_tdata
);

  localparam int AW = $clog2(SAVE_RAM_DEPTH);
  localparam logic [15:0] D1 = 16'(SAVE_RAM_DEPTH);
  localparam logic [15:0] D2 = 16'(2 * SAVE_RAM_DEPTH);
  localparam logic [15:0] D4 = 16'(4 * SAVE_RAM_DEPTH);

  logic [6:0]  prg_bank_count;
  logic [7:0]  bank_select_reg;
  logic [7:0]  bank_regs [8];
  logic        mirror_mode;
  logic [7:0]  ram_protect_reg;
  logic [7:0]  irq_latch_value;
  logic        irq_reload_flag;
  logic        irq_enable_flag;
  logic [7:0]  scanline_counter;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic [MAP_ADDR_W-1:0] out_mapped;
  logic                  out_rd_en;
  logic                  out_irq;
  logic                  out_mirror;
  logic [7:0]            ram_rdata;

  req_type_t   req;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        accept;

  assign req    = req_type_t'(s_tuser);
  assign addr   = s_tdata[15:0];
  assign wdata  = s_tdata[23:16];
  assign s_tready = !clearing && (!m_tvalid || m_tready);
  assign accept = s_tvalid && s_tready;

  // Save RAM index: low 13 address bits reduced modulo the RAM depth.
  logic [15:0]   idx_a, idx_b, idx_c;
  logic [AW-1:0] ram_idx;

  always_comb begin
    idx_a = {3'b000, addr[12:0]};
    if (idx_a >= D4) idx_a = idx_a - D4;
    idx_b = idx_a;
    if (idx_b >= D2) idx_b = idx_b - D2;
    idx_c = idx_b;
    if (idx_c >= D1) idx_c = idx_c - D1;
    ram_idx = idx_c[AW-1:0];
  end

  logic ram_en;
  logic ram_we;
  logic ram_re;

  assign ram_en = ram_protect_reg[RAM_EN_BIT];
  assign ram_re = accept && (req == REQ_RAM_READ);
  assign ram_we = accept && (req == REQ_RAM_WRITE) && ram_en && !ram_protect_reg[RAM_WP_BIT];

  bsm_ram #(
    .WIDTH(8),
    .DEPTH(SAVE_RAM_DEPTH)
  ) u_save_ram (
    .clk   (clk),
    .we    (clearing || ram_we),
    .waddr (clearing ? clr_addr : ram_idx),
    .wdata (clearing ? 8'h00 : wdata),
    .re    (ram_re),
    .raddr (ram_idx),
    .rdata (ram_rdata)
  );

  // Program address translation.
  logic [5:0]            second_last, last, prg_bank;
  logic [MAP_ADDR_W-1:0] cpu_mapped;

  always_comb begin
    second_last = 6'(prg_bank_count - 7'd2);
    last        = 6'(prg_bank_count - 7'd1);
    case (addr[14:13])
      2'd0:    prg_bank = bank_select_reg[PRG_SWAP_BIT] ? second_last : bank_regs[6][5:0];
      2'd1:    prg_bank = bank_regs[7][5:0];
      2'd2:    prg_bank = bank_select_reg[PRG_SWAP_BIT] ? bank_regs[6][5:0] : second_last;
      default: prg_bank = last;
    endcase
    if (!addr[15]) begin
      cpu_mapped = {3'b000, addr};
    end else begin
      cpu_mapped = {prg_bank, addr[12:0]};
    end
  end

  // Pattern address translation.
  logic                  vid_half;
  logic [2:0]            vid_reg;
  logic [7:0]            vid_bank;
  logic [MAP_ADDR_W-1:0] vid_mapped;

  always_comb begin
    vid_half = addr[12] ^ bank_select_reg[CHR_SWAP_BIT];
    if (!vid_half) begin
      vid_reg = {2'b00, addr[11]};
    end else begin
      vid_reg = 3'd2 + {1'b0, addr[11:10]};
    end
    vid_bank = bank_regs[vid_reg];
    if (addr >= VID_LIMIT) begin
      vid_mapped = {3'b000, addr};
    end else if (!vid_half) begin
      vid_mapped = {1'b0, vid_bank, 10'd0} + {8'd0, addr[10:0]};
    end else begin
      vid_mapped = {1'b0, vid_bank, addr[9:0]};
    end
  end

  // Scanline counter step.
  logic [7:0] counter_next;
  logic       tick_irq;

  always_comb begin
    if (scanline_counter == 8'd0 || irq_reload_flag) begin
      counter_next = irq_latch_value;
    end else begin
      counter_next = scanline_counter - 8'd1;
    end
    tick_irq = (counter_next == 8'd0) && irq_enable_flag;
  end

  // Bank register write value.
  logic [2:0] sel_reg;
  logic [7:0] bank_wval;

  always_comb begin
    sel_reg = bank_select_reg[2:0];
    if (sel_reg <= 3'd1) begin
      bank_wval = wdata & 8'hFE;
    end else if (sel_reg >= 3'd6) begin
      bank_wval = wdata & 8'h3F;
    end else begin
      bank_wval = wdata;
    end
  end

  logic reg_wr;
  assign reg_wr = accept && (req == REQ_REG_WRITE) && addr[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count    <= PRG_BANK_COUNT_RST;
      bank_select_reg   <= 8'd0;
      for (int i = 0; i < 8; i++) begin
        bank_regs[i] <= 8'd0;
      end
      mirror_mode       <= 1'b0;
      ram_protect_reg   <= 8'd0;
      irq_latch_value   <= 8'd0;
      irq_reload_flag   <= 1'b0;
      irq_enable_flag   <= 1'b0;
      scanline_counter  <= 8'd0;
      clearing          <= 1'b1;
      clr_addr          <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(SAVE_RAM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_PRG_BANK_COUNT: prg_bank_count <= cfg_data;
          CFG_INITIAL_MIRRORING: begin
            mirror_mode <= cfg_data[0];
          end
          default: ;
        endcase
      end

      if (reg_wr) begin
        case (addr[14:13])
          REG_BANK: begin
            if (!addr[0]) begin
              bank_select_reg <= wdata;
            end else begin
              bank_regs[sel_reg] <= bank_wval;
            end
          end
          REG_MIRR: begin
            if (!addr[0]) begin
              mirror_mode <= wdata[0];
            end else begin
              ram_protect_reg <= wdata;
            end
          end
          REG_IRQL: begin
            if (!addr[0]) begin
              irq_latch_value <= wdata;
            end else begin
              irq_reload_flag <= 1'b1;
            end
          end
          REG_IRQE: irq_enable_flag <= addr[0];
          default: ;
        endcase
      end

      if (accept && req == REQ_TICK) begin
        scanline_counter <= counter_next;
        irq_reload_flag  <= 1'b0;
      end

      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The mirroring bit is taken after this request's own update.
  logic mirror_after;

  always_comb begin
    mirror_after = mirror_mode;
    if (reg_wr && addr[14:13] == REG_MIRR && !addr[0]) begin
      mirror_after = wdata[0];
    end
  end

  logic [MAP_ADDR_W-1:0] mapped_next;
  logic                  rd_en_next;
  logic                  irq_next;

  always_comb begin
    mapped_next = '0;
    rd_en_next  = 1'b0;
    irq_next    = 1'b0;
    case (req)
      REQ_CPU_MAP:  mapped_next = cpu_mapped;
      REQ_VID_MAP:  mapped_next = vid_mapped;
      REQ_RAM_READ: rd_en_next  = ram_en;
      REQ_TICK:     irq_next    = tick_irq;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mapped <= mapped_next;
      out_rd_en  <= rd_en_next;
      out_irq    <= irq_next;
      out_mirror <= mirror_after;
    end
  end

  assign m_tdata = {3'b000, out_mirror, out_irq, (out_rd_en ? ram_rdata : 8'h00), out_mapped};

  // The request side stays closed for the whole clearing pass.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("request taken during save RAM clearing");

  // The two 2 KB pattern banks always hold an even bank number.
  assert property (@(posedge clk) disable iff (rst) !bank_regs[0][0] && !bank_regs[1][0])
    else $error("odd 2 KB pattern bank");

  // Program bank registers never carry bits above the 6-bit bank number.
  assert property (@(posedge clk) disable iff (rst)
      bank_regs[6][7:6] == 2'b00 && bank_regs[7][7:6] == 2'b00)
    else $error("program bank register out of range");

  // A tick always consumes a pending reload.
  assert property (@(posedge clk) disable iff (rst)
      accept && req == REQ_TICK |=> !irq_reload_flag)
    else $error("reload flag survived a tick");

  // A raised IRQ in the result implies the IRQ is still enabled.
  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && out_irq |-> irq_enable_flag)
    else $error("IRQ reported while disabled");

endmodule

[rtl/core/bsm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[dv/bank_switch_mapper_with_scanline_irq_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper testbench
// Drives requests into the mapper and checks each result against a predictor
// that tracks the bank, mirroring, RAM protect, IRQ and save RAM state. The
// run covers directed corner requests, a sweep of bank counts, and random
// traffic under several pacing mixes and output back-pressure.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq_top_tb;
  import bsm_pkg::*;

  localparam int RAM_DEPTH = 8192;
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [18:0] mapped;
    logic [7:0]  rdata;
    logic        irq;
    logic        mirror;
  } mapper_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_PRG_BANK_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;   // address[15:0], write_data[23:16]
  logic [2:0]            s_tuser = '0;   // req_type[2:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // mapped_address[18:0], read_data[26:19], irq_pending[27], mirroring[28]
  logic [31:0]           m_tdata;

  bank_switch_mapper_with_scanline_irq_top #(
    .SAVE_RAM_DEPTH(RAM_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [6:0] rom_banks;
  logic [7:0] bank_sel;
  logic [7:0] bank_file [8];
  logic       mirror_now;
  logic [7:0] ram_ctrl;
  logic [7:0] latch_val;
  logic       reload_pending;
  logic       irq_on;
  logic [7:0] line_count;
  logic [7:0] sram_img [RAM_DEPTH];

  mapper_result_t pending_results[$];
  int fail_count = 0;
  int results_seen = 0;
  int irq_seen = 0;
  int reads_hit = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic logic [18:0] prg_window(logic [5:0] bank, logic [15:0] addr);
    return {bank, addr[12:0]};
  endfunction

  function automatic mapper_result_t map_request(logic [2:0] kind, logic [15:0] addr,
                                                 logic [7:0] data);
    mapper_result_t r;
    logic [6:0] second_last;
    logic [6:0] last;
    logic       half;
    logic [2:0] sel;
    int         ram_idx;
    r = '0;
    second_last = rom_banks - 7'd2;
    last = rom_banks - 7'd1;
    ram_idx = int'(addr[12:0]) % RAM_DEPTH;
    case (kind)
      REQ_CPU_MAP: begin
        if (!addr[15]) begin
          r.mapped = {3'b000, addr};
        end else begin
          case (addr[14:13])
            REG_BANK: r.mapped = prg_window(bank_sel[PRG_SWAP_BIT] ? second_last[5:0]
                                                                    : bank_file[6][5:0], addr);
            REG_MIRR: r.mapped = prg_window(bank_file[7][5:0], addr);
            REG_IRQL: r.mapped = prg_window(bank_sel[PRG_SWAP_BIT] ? bank_file[6][5:0]
                                                                    : second_last[5:0], addr);
            default:  r.mapped = prg_window(last[5:0], addr);
          endcase
        end
      end
      REQ_REG_WRITE: begin
        if (addr[15]) begin
          case (addr[14:13])
            REG_BANK: begin
              if (!addr[0]) begin
                bank_sel = data;
              end else begin
                sel = bank_sel[2:0];
                if (sel <= 3'd1) bank_file[sel] = data & 8'hFE;
                else if (sel >= 3'd6) bank_file[sel] = data & 8'h3F;
                else bank_file[sel] = data;
              end
            end
            REG_MIRR: begin
              if (!addr[0]) mirror_now = data[0];
              else ram_ctrl = data;
            end
            REG_IRQL: begin
              if (!addr[0]) latch_val = data;
              else reload_pending = 1'b1;
            end
            default: irq_on = addr[0];
          endcase
        end
      end
      REQ_VID_MAP: begin
        if (addr >= VID_LIMIT) begin
          r.mapped = {3'b000, addr};
        end else begin
          half = addr[12] ^ bank_sel[CHR_SWAP_BIT];
          if (!half) r.mapped = ({11'd0, bank_file[addr[11]]} << 10) + {8'd0, addr[10:0]};
          else r.mapped = {1'b0, bank_file[3'd2 + {1'b0, addr[11:10]}], addr[9:0]};
        end
      end
      REQ_RAM_READ: begin
        if (ram_ctrl[RAM_EN_BIT]) r.rdata = sram_img[ram_idx];
      end
      REQ_RAM_WRITE: begin
        if (ram_ctrl[RAM_EN_BIT] && !ram_ctrl[RAM_WP_BIT]) sram_img[ram_idx] = data;
      end
      REQ_TICK: begin
        if (line_count == 8'd0 || reload_pending) begin
          line_count = latch_val;
          reload_pending = 1'b0;
        end else begin
          line_count = line_count - 8'd1;
        end
        r.irq = (line_count == 8'd0) && irq_on;
      end
      default: ;
    endcase
    r.mirror = mirror_now;
    return r;
  endfunction

  task automatic send_request(logic [2:0] kind, logic [15:0] addr, logic [7:0] data);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(map_request(kind, addr, data));
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRG_BANK_COUNT) begin
      rom_banks = value;
    end else begin
      mirror_now = value[0];
    end
    @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [1:0]  region;
    int          pick;
    pick = $urandom_range(99);
    addr = 16'($urandom);
    data = 8'($urandom);
    region = 2'($urandom);
    if (pick < 18) begin
      kind = REQ_CPU_MAP;
      if ($urandom_range(9) < 7) addr[15] = 1'b1;
    end else if (pick < 45) begin
      kind = REQ_REG_WRITE;
      addr[15:13] = {1'b1, region};
      if (region == REG_MIRR && addr[0]) begin
        case ($urandom_range(3))
          0: data = 8'h80;
          1: data = 8'hC0;
          2: data = 8'h00;
          default: ;
        endcase
      end else if (region == REG_IRQL && !addr[0] && $urandom_range(9) < 7) begin
        data = 8'($urandom_range(4));
      end
    end else if (pick < 58) begin
      kind = REQ_VID_MAP;
      if ($urandom_range(9) < 8) addr[15:13] = 3'b000;
    end else if (pick < 78) begin
      kind = (pick < 68) ? REQ_RAM_READ : REQ_RAM_WRITE;
      if ($urandom_range(3) != 0) addr[12:4] = 9'd0;
    end else if (pick < 95) begin
      kind = REQ_TICK;
    end else if (pick < 98) begin
      kind = $urandom_range(1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
    end else begin
      kind = REQ_REG_WRITE;
      addr[15] = 1'b0;
    end
    send_request(kind, addr, data);
  endtask

  task automatic test_directed();
    send_request(REQ_CPU_MAP, 16'h0000, 8'h00);
    send_request(REQ_CPU_MAP, 16'h8000, 8'hFF);
    send_request(REQ_CPU_MAP, 16'hE000, 8'h00);
    send_request(REQ_REG_WRITE, 16'h8000, 8'h46);
    send_request(REQ_REG_WRITE, 16'h8001, 8'hFF);
    send_request(REQ_CPU_MAP, 16'h9FFF, 8'h00);
    send_request(REQ_CPU_MAP, 16'hDFFF, 8'h00);
    send_request(REQ_REG_WRITE, 16'h8000, 8'h80);
    send_request(REQ_REG_WRITE, 16'h8001, 8'hFF);
    send_request(REQ_VID_MAP, 16'h1000, 8'h00);
    send_request(REQ_VID_MAP, 16'h0FFF, 8'h00);
    send_request(REQ_REG_WRITE, 16'hA000, 8'h01);
    send_request(REQ_RAM_READ, 16'h6000, 8'h00);
    send_request(REQ_REG_WRITE, 16'hA001, 8'h80);
    send_request(REQ_RAM_WRITE, 16'h7FFF, 8'hFF);
    send_request(REQ_RAM_READ, 16'hFFFF, 8'h00);
    send_request(REQ_REG_WRITE, 16'hA001, 8'hC0);
    send_request(REQ_RAM_WRITE, 16'h7FFF, 8'h00);
    send_request(REQ_RAM_READ, 16'h7FFF, 8'h00);
    send_request(REQ_REG_WRITE, 16'hC000, 8'h01);
    send_request(REQ_REG_WRITE, 16'hE001, 8'h00);
    send_request(REQ_TICK, 16'h0000, 8'h00);
    send_request(REQ_TICK, 16'hFFFF, 8'hFF);
    send_request(REQ_UNUSED_6, 16'hFFFF, 8'hFF);
    send_request(REQ_UNUSED_7, 16'h8001, 8'hFF);
    send_request(REQ_REG_WRITE, 16'h7FFF, 8'hFF);
    wait_drained();
  endtask

  task automatic test_bank_count_sweep();
    logic [6:0] counts [7] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127, 7'd37};
    for (int i = 0; i < 7; i++) begin
      write_config(CFG_PRG_BANK_COUNT, counts[i]);
      write_config(CFG_INITIAL_MIRRORING, {6'($urandom), i[0]});
      send_request(REQ_REG_WRITE, 16'h8000, 8'h00);
      send_request(REQ_CPU_MAP, 16'h8000, 8'($urandom));
      send_request(REQ_CPU_MAP, 16'hA000, 8'($urandom));
      send_request(REQ_CPU_MAP, 16'hC000, 8'($urandom));
      send_request(REQ_CPU_MAP, 16'hE000, 8'($urandom));
      send_request(REQ_REG_WRITE, 16'h8000, 8'h40);
      send_request(REQ_CPU_MAP, 16'h9FFF, 8'($urandom));
      send_request(REQ_CPU_MAP, 16'hDFFF, 8'($urandom));
      send_request(REQ_CPU_MAP, 16'hFFFF, 8'($urandom));
      wait_drained();
    end
  endtask

  task automatic test_pacing(int sender_idle, int receiver_stall, int count);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    if ($urandom_range(4) != 0) write_config(CFG_PRG_BANK_COUNT, 7'($urandom_range(2, 64)));
    else write_config(CFG_PRG_BANK_COUNT, 7'($urandom));
    write_config(CFG_INITIAL_MIRRORING, 7'($urandom));
    repeat (count) send_random_request();
    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_output_hold_off();
    hold_len = 250;
    hold_asked++;
    repeat (40) send_random_request();
    wait_drained();
  endtask

  task automatic test_sender_pause();
    stall_pct = 30;
    repeat (20) send_random_request();
    wait_drained();
    repeat (20) send_random_request();
    wait_drained();
    stall_pct = 0;
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= hold_len;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    mapper_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: m_tdata=%h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (m_tdata[18:0] !== want.mapped) begin
          $error("mapped_address: expected %h, got %h", want.mapped, m_tdata[18:0]);
          fail_count++;
        end
        if (m_tdata[26:19] !== want.rdata) begin
          $error("read_data: expected %h, got %h", want.rdata, m_tdata[26:19]);
          fail_count++;
        end
        if (m_tdata[27] !== want.irq) begin
          $error("irq_pending: expected %b, got %b", want.irq, m_tdata[27]);
          fail_count++;
        end
        if (m_tdata[28] !== want.mirror) begin
          $error("mirroring: expected %b, got %b", want.mirror, m_tdata[28]);
          fail_count++;
        end
        if (want.irq) irq_seen++;
        if (want.rdata != 8'd0) reads_hit++;
      end
    end
  end

  initial begin
    rom_banks = PRG_BANK_COUNT_RST;
    bank_sel = '0;
    foreach (bank_file[i]) bank_file[i] = '0;
    mirror_now = 1'b0;
    ram_ctrl = '0;
    latch_val = '0;
    reload_pending = 1'b0;
    irq_on = 1'b0;
    line_count = '0;
    foreach (sram_img[i]) sram_img[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_bank_count_sweep();
    test_pacing(0, 0, 450);
    test_pacing(78, 0, 400);
    test_pacing(0, 78, 400);
    test_pacing(18, 18, 450);
    test_output_hold_off();
    test_sender_pause();
    repeat (20) @(posedge clk);
    $display("Checked %0d requests over directed, bank count, pacing and back-pressure tests.",
             results_seen);
    $display("Saw %0d IRQ assertions and %0d nonzero save RAM reads.", irq_seen, reads_hit);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/bsm_pkg.sv
rtl/core/bsm_ram.sv
rtl/core/bank_switch_mapper_with_scanline_irq_top.sv
dv/bank_switch_mapper_with_scanline_irq_top_tb.sv
